// ----- src/pq_pkg.sv -----
// shared types and constants of the min priority queue
package pq_pkg;

    localparam int KEY_W = 16;
    localparam int TAG_W = 16;

    localparam logic signed [TAG_W-1:0] EMPTY_TAG  = -16'sd1;
    localparam logic signed [TAG_W-1:0] INSERT_TAG = 16'sd0;

    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic signed [TAG_W-1:0] tag;
        logic                    ok;
    } result_t;

endpackage

// ----- src/pq_mem.sv -----
// entry store: one write port, one read port with registered read data
module pq_mem
    import pq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  entry_t                   wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output entry_t                   rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/pq_ctrl.sv -----
// sequencer: insert, minimum scan and compaction over the entry store
module pq_ctrl
    import pq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  op_t                         in_op,
    input  logic signed [TAG_W-1:0]     in_tag,
    input  logic signed [KEY_W-1:0]     in_key,
    output logic                        res_valid,
    input  logic                        res_ready,
    output result_t                     res,
    output logic                        wr_en,
    output logic [$clog2(CAPACITY)-1:0] wr_addr,
    output entry_t                      wr_data,
    output logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  entry_t                      rd_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic signed [KEY_W-1:0] best_key_reg, best_key_next;
    logic signed [TAG_W-1:0] best_tag_reg, best_tag_next;
    logic                    first_reg, first_next;
    result_t                 res_reg, res_next;

    logic [CNT_W-1:0] count_dec;
    logic [IDX_W-1:0] last_idx;
    logic             take;
    logic [IDX_W-1:0] nb_idx;
    logic signed [TAG_W-1:0] nb_tag;

    assign count_dec = count_reg - CNT_W'(1);
    assign last_idx  = count_dec[IDX_W-1:0];
    assign take      = first_reg || (rd_data.key < best_key_reg);
    assign nb_idx    = take ? rd_idx_reg : best_idx_reg;
    assign nb_tag    = take ? rd_data.tag : best_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
        best_tag_reg <= best_tag_next;
        first_reg    <= first_next;
        res_reg      <= res_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        best_idx_next = best_idx_reg;
        best_key_next = best_key_reg;
        best_tag_next = best_tag_reg;
        first_next    = first_reg;
        res_next      = res_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '{key: in_key, tag: in_tag};
        rd_addr       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_op == OP_INSERT) begin
                        res_next.tag = INSERT_TAG;
                        if (count_reg < CNT_W'(CAPACITY)) begin
                            wr_en       = 1'b1;
                            wr_addr     = count_reg[IDX_W-1:0];
                            count_next  = count_reg + CNT_W'(1);
                            res_next.ok = 1'b1;
                        end else begin
                            res_next.ok = 1'b0;
                        end
                        state_next = ST_DONE;
                    end else if (count_reg == '0) begin
                        res_next   = '{tag: EMPTY_TAG, ok: 1'b0};
                        state_next = ST_DONE;
                    end else begin
                        rd_addr     = last_idx;
                        rd_idx_next = last_idx;
                        first_next  = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // newest to oldest, only a strictly smaller key replaces
                first_next    = 1'b0;
                best_idx_next = nb_idx;
                best_key_next = take ? rd_data.key : best_key_reg;
                best_tag_next = nb_tag;
                if (rd_idx_reg == '0) begin
                    res_next = '{tag: nb_tag, ok: 1'b1};
                    if (nb_idx == last_idx) begin
                        count_next = count_dec;
                        state_next = ST_DONE;
                    end else begin
                        rd_addr     = nb_idx + IDX_W'(1);
                        rd_idx_next = nb_idx + IDX_W'(1);
                        state_next  = ST_SHIFT;
                    end
                end else begin
                    rd_addr     = rd_idx_reg - IDX_W'(1);
                    rd_idx_next = rd_idx_reg - IDX_W'(1);
                end
            end
            ST_SHIFT: begin
                // move each younger entry down one slot
                wr_en   = 1'b1;
                wr_addr = rd_idx_reg - IDX_W'(1);
                wr_data = rd_data;
                if (rd_idx_reg == last_idx) begin
                    count_next = count_dec;
                    state_next = ST_DONE;
                end else begin
                    rd_addr     = rd_idx_reg + IDX_W'(1);
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

// ----- src/min_priority_queue_top.sv -----
// top level of the min priority queue with its result register
//
// A bounded queue of signed 16-bit (tag, key) pairs held in a single-port-write,
// single-port-read memory. Requests are taken one at a time. An insert on a
// full queue is refused with ok low. An extract reads every held entry once,
// newest first, one per cycle, picks the first strictly smallest key, then
// moves each younger entry down one slot, one per cycle, as the memory allows
// one read and one write per cycle. An extract on an empty queue returns tag
// -1 with ok low. A finished result waits in an output register, so the next
// request is taken while it is still unread.
module min_priority_queue_top
    import pq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // item_tag, item_key
    input  logic [0:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // result_tag
    output logic [0:0]  m_tuser    // ok
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic             res_valid;
    logic             res_ready;
    result_t          res;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;

    logic    m_valid_reg;
    result_t m_res_reg;

    pq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tuser[0])),
        .in_tag    (s_tdata[15:0]),
        .in_key    (s_tdata[31:16]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    pq_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_res_reg.tag;
    assign m_tuser[0] = m_res_reg.ok;

endmodule

// ----- src/pq_checker.sv -----
// port-level checks of the min priority queue, bound to the top level
module pq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    logic [1:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else if (in_acc && !out_acc) begin
            pend_reg <= pend_reg + 2'd1;
        end else if (out_acc && !in_acc) begin
            pend_reg <= pend_reg - 2'd1;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_fail_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata == 16'h0000) || (m_tdata == 16'hFFFF))
        else $error("refused request with unexpected tag");

    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result without a request");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == 2'd2 |-> !in_acc)
        else $error("too many requests in flight");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind min_priority_queue_top pq_checker u_pq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- sim/min_priority_queue_checker.sv -----
// request and result monitor with an in-order predictor of the min priority queue
module min_priority_queue_checker
    import pq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // item_tag, item_key
    input  logic [0:0]  s_tuser,   // opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // result_tag
    input  logic [0:0]  m_tuser,   // ok
    output int          fail_count,
    output int          pending,
    output int          n_inserts,
    output int          n_refused,
    output int          n_extracts,
    output int          n_empty,
    output int          n_ties
);

    timeunit 1ns;
    timeprecision 1ps;

    logic signed [KEY_W-1:0] held_keys [CAPACITY];
    logic signed [TAG_W-1:0] held_tags [CAPACITY];
    int                      held_count;
    result_t                 due_results [$];
    result_t                 want;
    int                      n_results;

    function automatic result_t apply_request(op_t op, logic signed [TAG_W-1:0] tag,
                                              logic signed [KEY_W-1:0] key);
        result_t r;
        int      pick;
        int      i;
        bit      tie;
        r.tag = INSERT_TAG;
        r.ok  = 1'b0;
        if (op == OP_INSERT) begin
            n_inserts++;
            if (held_count >= CAPACITY) begin
                n_refused++;
            end else begin
                held_keys[held_count] = key;
                held_tags[held_count] = tag;
                held_count++;
                r.ok = 1'b1;
            end
        end else begin
            n_extracts++;
            if (held_count == 0) begin
                r.tag = EMPTY_TAG;
                n_empty++;
            end else begin
                // newest first, only a strictly smaller key takes over
                pick = held_count - 1;
                for (i = held_count - 2; i >= 0; i--) begin
                    if (held_keys[i] < held_keys[pick]) pick = i;
                end
                tie = 1'b0;
                for (i = 0; i < held_count; i++) begin
                    if (i != pick && held_keys[i] == held_keys[pick]) tie = 1'b1;
                end
                if (tie) n_ties++;
                r.tag = held_tags[pick];
                r.ok  = 1'b1;
                for (i = pick; i < held_count - 1; i++) begin
                    held_keys[i] = held_keys[i + 1];
                    held_tags[i] = held_tags[i + 1];
                end
                held_count--;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_count = 0;
            fail_count = 0;
            n_inserts  = 0;
            n_refused  = 0;
            n_extracts = 0;
            n_empty    = 0;
            n_ties     = 0;
            n_results  = 0;
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (due_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d: unexpected, tag %0d ok %0d", n_results,
                                 $signed(m_tdata), m_tuser[0]);
                end else begin
                    want = due_results.pop_front();
                    if (m_tdata !== want.tag || m_tuser[0] !== want.ok) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result %0d: expected tag %0d ok %0d, got tag %0d ok %0d",
                                     n_results, want.tag, want.ok, $signed(m_tdata),
                                     m_tuser[0]);
                    end
                end
            end
            // pop before push: a request cannot produce its result at the same edge
            if (s_tvalid && s_tready)
                due_results.push_back(apply_request(op_t'(s_tuser[0]), s_tdata[15:0],
                                                    s_tdata[31:16]));
        end
        pending <= due_results.size();
    end

endmodule

// ----- sim/tb.sv -----
// testbench top: clock, reset, request stimulus, result sink and verdict
module tb
    import pq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = 16;
    localparam int SINK_HOLD  = 300;
    localparam int QUIET_MAX  = 4000;
    localparam int N_PHASES   = 16;
    localparam int PHASE_LEN  = 50;

    localparam logic [15:0] FILL_KEYS [16] = '{
        16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h0064, 16'h7FFF,
        16'h8001, 16'hFFFF, 16'h1234, 16'h8000, 16'hFFFE, 16'h0000, 16'h4000, 16'hC000
    };
    localparam logic [15:0] FILL_TAGS [16] = '{
        16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0,
        16'h0001, 16'h8001, 16'h7FFE, 16'h3C3C, 16'hC3C3, 16'h1111, 16'hEEEE, 16'h0100
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    int fail_count;
    int pending;
    int n_inserts;
    int n_refused;
    int n_extracts;
    int n_empty;
    int n_ties;

    bit steady     = 1'b0;
    bit stall_sink = 1'b0;
    bit stall_done = 1'b0;
    int quiet_cycles = 0;

    always #1 aclk = ~aclk;

    min_priority_queue_top #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    min_priority_queue_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .fail_count(fail_count),
        .pending   (pending),
        .n_inserts (n_inserts),
        .n_refused (n_refused),
        .n_extracts(n_extracts),
        .n_empty   (n_empty),
        .n_ties    (n_ties)
    );

    task automatic send_request(input op_t op, input logic [15:0] tag, input logic [15:0] key);
        while (!steady && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {key, tag};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        @(posedge aclk);
    endtask

    // result sink
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_sink && !stall_done) begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD) @(posedge aclk);
                stall_done = 1'b1;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 24);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("timeout: no request or result moved for %0d cycles", QUIET_MAX);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int          ins_pct;
        bit          narrow;
        op_t         op;
        logic [15:0] key;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty extract, fill with extreme and repeated keys, refused insert, tie picks
        send_request(OP_EXTRACT, 16'h5A5A, 16'hA5A5);
        for (int i = 0; i < 16; i++) send_request(OP_INSERT, FILL_TAGS[i], FILL_KEYS[i]);
        send_request(OP_INSERT, 16'h7777, 16'h8000);
        repeat (5) send_request(OP_EXTRACT, 16'($urandom), 16'($urandom));

        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase % 4)
                0: ins_pct = 85;
                1: ins_pct = 15;
                2: ins_pct = 55;
                default: ins_pct = 45;
            endcase
            narrow = phase[1];
            steady = (phase == 5 || phase == 6);
            if (phase == 4) stall_sink = 1'b1;
            if (phase == 10) drain_results();
            for (int n = 0; n < PHASE_LEN; n++) begin
                op  = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_EXTRACT;
                key = narrow ? 16'($urandom_range(8)) - 16'd4 : 16'($urandom);
                send_request(op, 16'($urandom), key);
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (2 * CAPACITY + 4) @(posedge aclk);
        $display("covered %0d inserts (%0d refused on a full queue) and %0d extracts",
                 n_inserts, n_refused, n_extracts);
        $display("  (%0d on an empty queue, %0d chosen among equal smallest keys)",
                 n_empty, n_ties);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
